### design/joint_angle_pid_controller_unit_defines.svh
// Assertion macros used by the checker file of the joint angle PID unit
`ifndef JOINT_ANGLE_PID_CONTROLLER_UNIT_DEFINES_SVH
`define JOINT_ANGLE_PID_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define JAPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define JAPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/japc_pkg.sv
// Types and constants shared by the joint angle PID controller modules
package japc_pkg;

    localparam int ANGLE_FRAC_BITS = 8;
    localparam int GAIN_SHIFT      = 8 + ANGLE_FRAC_BITS;
    localparam int MAX_DUTY        = 230;

    // internal angle width: holds offset + target - calibrated angle
    localparam int ANG_W = 20;
    localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [ANG_W-1:0] DEG360 = ANG_W'(360 << ANGLE_FRAC_BITS);

    localparam int ERR_W  = 18;
    localparam int SUM_W  = 24;
    localparam int DERR_W = ERR_W + 1;
    localparam int OFF_W  = 18;
    localparam int P_W    = 17 + ERR_W;
    localparam int I_W    = 17 + SUM_W;
    localparam int D_W    = 17 + DERR_W;
    localparam int ACC_W  = I_W + 1;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_TARGET = 2'd1,
        REQ_SWITCH = 2'd2
    } req_t;

    localparam logic [2:0] CFG_KP_A        = 3'd0;
    localparam logic [2:0] CFG_KI_A        = 3'd1;
    localparam logic [2:0] CFG_KD_A        = 3'd2;
    localparam logic [2:0] CFG_KP_D        = 3'd3;
    localparam logic [2:0] CFG_KI_D        = 3'd4;
    localparam logic [2:0] CFG_KD_D        = 3'd5;
    localparam logic [2:0] CFG_INT_LIMIT   = 3'd6;
    localparam logic [2:0] CFG_INIT_OFFSET = 3'd7;

    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
    } gains_t;

    typedef struct packed {
        gains_t      set_a;
        gains_t      set_d;
        logic [22:0] limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [16:0]        angle_sample;
        logic signed [16:0] target_angle;
        logic               link_select;
    } item_t;

    typedef struct packed {
        logic                  tick;
        logic signed [P_W-1:0] p_term;
        logic signed [I_W-1:0] i_term;
        logic signed [D_W-1:0] d_term;
        logic                  gain_set;
        logic                  set_changed;
    } prod_t;

endpackage

### design/japc_cfg.sv
// Gain set and integral limit registers behind the write port
module japc_cfg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_index,
    input  logic [22:0]      cfg_data,
    output japc_pkg::cfg_t   cfg
);

    japc_pkg::cfg_t cfg_reg;
    japc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                japc_pkg::CFG_KP_A:      cfg_next.set_a.kp = cfg_data[15:0];
                japc_pkg::CFG_KI_A:      cfg_next.set_a.ki = cfg_data[15:0];
                japc_pkg::CFG_KD_A:      cfg_next.set_a.kd = cfg_data[15:0];
                japc_pkg::CFG_KP_D:      cfg_next.set_d.kp = cfg_data[15:0];
                japc_pkg::CFG_KI_D:      cfg_next.set_d.ki = cfg_data[15:0];
                japc_pkg::CFG_KD_D:      cfg_next.set_d.kd = cfg_data[15:0];
                japc_pkg::CFG_INT_LIMIT: cfg_next.limit    = cfg_data;
                // offset is only loaded at reset, where the tracking offset resets to zero;
                // this index holds no register, so a write never reaches the datapath
                japc_pkg::CFG_INIT_OFFSET: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_a.kp <= 16'd256;
            cfg_reg.set_a.ki <= 16'd0;
            cfg_reg.set_a.kd <= 16'd0;
            cfg_reg.set_d.kp <= 16'd256;
            cfg_reg.set_d.ki <= 16'd0;
            cfg_reg.set_d.kd <= 16'd0;
            cfg_reg.limit    <= 23'd25600;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/japc_track.sv
// Input register, error/offset tracking state and the three gain products
module japc_track (
    input  logic              clk,
    input  logic              rst_n,
    input  japc_pkg::cfg_t    cfg,
    input  japc_pkg::item_t   in_item,
    input  logic              in_valid,
    output logic              in_ready,
    output japc_pkg::prod_t   prod,
    output logic              prod_valid,
    input  logic              prod_ready
);

    localparam int AW = japc_pkg::ANG_W;

    japc_pkg::item_t item_reg;
    logic            item_valid_reg;
    japc_pkg::prod_t prod_reg;
    japc_pkg::prod_t prod_next;
    logic            prod_valid_reg;

    logic signed [16:0]                   target_reg;
    logic signed [16:0]                   target_next;
    logic signed [japc_pkg::SUM_W-1:0]    esum_reg;
    logic signed [japc_pkg::SUM_W-1:0]    esum_next;
    logic signed [japc_pkg::ERR_W-1:0]    prev_err_reg;
    logic signed [japc_pkg::ERR_W-1:0]    prev_err_next;
    logic signed [japc_pkg::OFF_W-1:0]    offset_reg;
    logic signed [japc_pkg::OFF_W-1:0]    offset_next;
    logic                                 active_set_reg;
    logic                                 active_set_next;

    logic                                 stage_ready;
    logic                                 fire;
    logic signed [AW-1:0]                 cal_raw;
    logic signed [AW-1:0]                 cal;
    logic signed [AW-1:0]                 err_raw;
    logic signed [AW-1:0]                 err_hi;
    logic signed [AW-1:0]                 err_wrap;
    logic signed [japc_pkg::ERR_W-1:0]    err;
    logic signed [japc_pkg::SUM_W:0]      sum_raw;
    logic signed [japc_pkg::SUM_W:0]      lim;
    logic signed [japc_pkg::SUM_W-1:0]    sum_clamped;
    logic signed [japc_pkg::DERR_W-1:0]   derr;
    logic signed [AW-1:0]                 off_raw;
    logic signed [AW-1:0]                 off_wrap;
    logic signed [AW-1:0]                 off_cand;
    japc_pkg::gains_t                     gains;
    logic signed [16:0]                   kp_s;
    logic signed [16:0]                   ki_s;
    logic signed [16:0]                   kd_s;

    assign stage_ready = !prod_valid_reg || prod_ready;
    assign fire        = item_valid_reg && stage_ready;
    assign in_ready    = !item_valid_reg || stage_ready;

    // calibrated angle and control error, one wrap step each
    always_comb
    begin
        cal_raw = AW'($signed({1'b0, item_reg.angle_sample})) + AW'(offset_reg);
        cal     = (cal_raw > japc_pkg::DEG180) ? cal_raw - japc_pkg::DEG360 : cal_raw;
        err_raw = AW'(target_reg) - cal;
        err_hi  = (err_raw > japc_pkg::DEG180) ? err_raw - japc_pkg::DEG360 : err_raw;
        err_wrap = (err_hi < -japc_pkg::DEG180) ? err_hi + japc_pkg::DEG360 : err_hi;
        err     = japc_pkg::ERR_W'(err_wrap);

        sum_raw = (japc_pkg::SUM_W+1)'(esum_reg) + (japc_pkg::SUM_W+1)'(err);
        lim     = $signed({2'b00, cfg.limit});
        if (sum_raw > lim)
            sum_clamped = japc_pkg::SUM_W'(lim);
        else if (sum_raw < -lim)
            sum_clamped = japc_pkg::SUM_W'(-lim);
        else
            sum_clamped = japc_pkg::SUM_W'(sum_raw);

        derr = japc_pkg::DERR_W'(err) - japc_pkg::DERR_W'(prev_err_reg);
    end

    // re-based offset, full wrap into (-180, 180]: try each period shift
    always_comb
    begin
        off_raw  = AW'(offset_reg) + AW'(target_reg) - cal;
        off_wrap = off_raw;
        off_cand = off_raw;
        for (int k = -3; k <= 3; k++)
        begin
            off_cand = off_raw + AW'(k) * japc_pkg::DEG360;
            if (off_cand > -japc_pkg::DEG180 && off_cand <= japc_pkg::DEG180)
                off_wrap = off_cand;
        end
    end

    always_comb
    begin
        gains = active_set_reg ? cfg.set_d : cfg.set_a;
        kp_s  = $signed({1'b0, gains.kp});
        ki_s  = $signed({1'b0, gains.ki});
        kd_s  = $signed({1'b0, gains.kd});

        target_next     = target_reg;
        esum_next       = esum_reg;
        prev_err_next   = prev_err_reg;
        offset_next     = offset_reg;
        active_set_next = active_set_reg;

        prod_next.tick        = 1'b0;
        prod_next.p_term      = japc_pkg::P_W'(kp_s) * japc_pkg::P_W'(err);
        prod_next.i_term      = japc_pkg::I_W'(ki_s) * japc_pkg::I_W'(sum_clamped);
        prod_next.d_term      = japc_pkg::D_W'(kd_s) * japc_pkg::D_W'(derr);
        prod_next.gain_set    = active_set_reg;
        prod_next.set_changed = 1'b0;

        case (item_reg.req_type)
            japc_pkg::REQ_TICK:
            begin
                prod_next.tick = 1'b1;
                esum_next      = sum_clamped;
                prev_err_next  = err;
            end
            japc_pkg::REQ_TARGET:
            begin
                target_next = item_reg.target_angle;
            end
            japc_pkg::REQ_SWITCH:
            begin
                offset_next           = japc_pkg::OFF_W'(off_wrap);
                active_set_next       = item_reg.link_select;
                prod_next.gain_set    = item_reg.link_select;
                prod_next.set_changed = item_reg.link_select != active_set_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            target_reg     <= '0;
            esum_reg       <= '0;
            prev_err_reg   <= '0;
            offset_reg     <= '0;
            active_set_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= in_valid;
            if (stage_ready)
                prod_valid_reg <= item_valid_reg;
            if (fire)
            begin
                target_reg     <= target_next;
                esum_reg       <= esum_next;
                prev_err_reg   <= prev_err_next;
                offset_reg     <= offset_next;
                active_set_reg <= active_set_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
        if (fire)
            prod_reg <= prod_next;
    end

    assign prod       = prod_reg;
    assign prod_valid = prod_valid_reg;

endmodule

### design/japc_drive.sv
// Effort sum, truncation and saturation, held drive and the output register
module japc_drive (
    input  logic               clk,
    input  logic               rst_n,
    input  japc_pkg::prod_t    prod,
    input  logic               prod_valid,
    output logic               prod_ready,
    output logic signed [8:0]  drive,
    output logic [7:0]         pwm_forward,
    output logic [7:0]         pwm_reverse,
    output logic               gain_set,
    output logic               set_changed,
    output logic               out_valid,
    input  logic               out_ready
);

    localparam int AC = japc_pkg::ACC_W;

    logic signed [8:0] held_reg;
    logic signed [8:0] drive_reg;
    logic signed [8:0] drive_next;
    logic [7:0]        fwd_reg;
    logic [7:0]        fwd_next;
    logic [7:0]        rev_reg;
    logic [7:0]        rev_next;
    logic              gain_reg;
    logic              changed_reg;
    logic              out_valid_reg;

    logic                fire;
    logic signed [AC-1:0] acc;
    logic [AC-1:0]        mag;
    logic [AC-1:0]        mag_sh;
    logic [7:0]           eff;
    logic signed [8:0]    eff_s;
    logic signed [8:0]    tick_drive;
    logic [7:0]           drive_mag;

    assign prod_ready = !out_valid_reg || out_ready;
    assign fire       = prod_valid && prod_ready;

    always_comb
    begin
        acc = AC'($signed(prod.p_term)) + AC'($signed(prod.i_term))
            + AC'($signed(prod.d_term));
        mag    = acc[AC-1] ? AC'(-acc) : AC'(acc);
        // shift of the magnitude gives truncation toward zero
        mag_sh = mag >> japc_pkg::GAIN_SHIFT;
        if (mag_sh > AC'(japc_pkg::MAX_DUTY))
            eff = 8'(japc_pkg::MAX_DUTY);
        else
            eff = mag_sh[7:0];
        eff_s      = $signed({1'b0, eff});
        tick_drive = acc[AC-1] ? -eff_s : eff_s;

        drive_next = prod.tick ? tick_drive : held_reg;
        drive_mag  = drive_next[8] ? 8'(-drive_next) : drive_next[7:0];
        fwd_next   = drive_next[8] ? drive_mag : 8'd0;
        rev_next   = drive_next[8] ? 8'd0 : drive_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (prod_ready)
                out_valid_reg <= prod_valid;
            if (fire && prod.tick)
                held_reg <= tick_drive;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            drive_reg   <= drive_next;
            fwd_reg     <= fwd_next;
            rev_reg     <= rev_next;
            gain_reg    <= prod.gain_set;
            changed_reg <= prod.set_changed;
        end
    end

    assign drive       = drive_reg;
    assign pwm_forward = fwd_reg;
    assign pwm_reverse = rev_reg;
    assign gain_set    = gain_reg;
    assign set_changed = changed_reg;
    assign out_valid   = out_valid_reg;

endmodule

### design/joint_angle_pid_controller_unit.sv
// Path: a word accepted into the input register passes the gain product register, then the output register.
// Throughput: one word per cycle while out_ready does not stall; tracking state updates in one registered pass.
// Stages: input register, gain product register (three multipliers), output register.
// Reset (async, active low) clears valids, target, integral, previous error, offset,
// held drive and gain set select, and reloads the gain and limit registers.
module joint_angle_pid_controller_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [22:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [16:0]        angle_sample,
    input  logic signed [16:0] target_angle,
    input  logic               link_select,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [8:0]  drive,
    output logic [7:0]         pwm_forward,
    output logic [7:0]         pwm_reverse,
    output logic               gain_set,
    output logic               set_changed
);

    japc_pkg::cfg_t  cfg;
    japc_pkg::item_t in_item;
    japc_pkg::prod_t prod;
    logic            prod_valid;
    logic            prod_ready;

    assign in_item.req_type     = req_type;
    assign in_item.angle_sample = angle_sample;
    assign in_item.target_angle = target_angle;
    assign in_item.link_select  = link_select;

    japc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    japc_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_item    (in_item),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .prod       (prod),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready)
    );

    japc_drive u_drive (
        .clk         (clk),
        .rst_n       (rst_n),
        .prod        (prod),
        .prod_valid  (prod_valid),
        .prod_ready  (prod_ready),
        .drive       (drive),
        .pwm_forward (pwm_forward),
        .pwm_reverse (pwm_reverse),
        .gain_set    (gain_set),
        .set_changed (set_changed),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

endmodule

### design/japc_checker.sv
// Port-level checks for the joint angle PID unit, bound to the top level
`include "joint_angle_pid_controller_unit_defines.svh"

module japc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic signed [8:0] drive,
    input logic [7:0]        pwm_forward,
    input logic [7:0]        pwm_reverse
);

    `JAPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive), "result word dropped or changed while stalled")
    `JAPC_ASSERT_NOW(a_drive_range, out_valid, drive <= japc_pkg::MAX_DUTY && drive >= -japc_pkg::MAX_DUTY, "drive outside saturation range")
    `JAPC_ASSERT_NOW(a_pwm_reverse, out_valid && !drive[8], pwm_forward == 8'd0 && pwm_reverse == drive[7:0], "reverse duty does not follow drive")
    `JAPC_ASSERT_NOW(a_pwm_forward, out_valid && drive[8], pwm_reverse == 8'd0 && pwm_forward == 8'(-drive), "forward duty does not follow drive")

endmodule

bind joint_angle_pid_controller_unit japc_checker u_japc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drive       (drive),
    .pwm_forward (pwm_forward),
    .pwm_reverse (pwm_reverse)
);

### verif/japc_effort_check.sv
`timescale 1ns / 1ps
// Effort checker for the joint angle PID unit: predicts each result word and compares it
module japc_effort_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [22:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [16:0]        angle_sample,
    input  logic signed [16:0] target_angle,
    input  logic               link_select,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [8:0]  drive,
    input  logic [7:0]         pwm_forward,
    input  logic [7:0]         pwm_reverse,
    input  logic               gain_set,
    input  logic               set_changed,
    output int                 mismatch_count,
    output int                 efforts_due
);

    localparam longint HALF_TURN = longint'(180) << japc_pkg::ANGLE_FRAC_BITS;
    localparam longint FULL_TURN = longint'(360) << japc_pkg::ANGLE_FRAC_BITS;

    typedef struct packed {
        logic signed [8:0] drive;
        logic [7:0]        pwm_forward;
        logic [7:0]        pwm_reverse;
        logic              gain_set;
        logic              set_changed;
    } effort_t;

    japc_pkg::gains_t   gain_bank [2];
    logic [22:0]        sum_limit;
    logic signed [17:0] target_q;
    logic signed [17:0] prev_err_q;
    logic signed [17:0] offset_q;
    logic signed [23:0] error_sum_q;
    logic signed [8:0]  held_drive_q;
    logic               active_q;

    effort_t          pending_efforts [$];
    effort_t          want_word;
    effort_t          seen_word;
    japc_pkg::item_t  in_word;

    function automatic longint wrap_half_turn(input longint x);
        longint r;
        r = ((x % FULL_TURN) + FULL_TURN) % FULL_TURN;
        if (r > HALF_TURN)
            r -= FULL_TURN;
        return r;
    endfunction

    task automatic advance_joint(input japc_pkg::item_t w, output effort_t r);
        longint cal;
        longint err;
        longint sum;
        longint lim;
        longint acc;
        longint mag;
        longint d;
        japc_pkg::gains_t g;
        r.set_changed = 1'b0;
        // single wrap step only, out-of-range samples are not folded further
        cal = longint'(w.angle_sample) + longint'(offset_q);
        if (cal > HALF_TURN)
            cal -= FULL_TURN;
        case (w.req_type)
            japc_pkg::REQ_TICK:
            begin
                err = longint'(target_q) - cal;
                if (err > HALF_TURN)
                    err -= FULL_TURN;
                if (err < -HALF_TURN)
                    err += FULL_TURN;
                lim = longint'(sum_limit);
                sum = longint'(error_sum_q) + err;
                if (sum > lim)
                    sum = lim;
                if (sum < -lim)
                    sum = -lim;
                g = gain_bank[active_q];
                acc = longint'(g.kp) * err + longint'(g.ki) * sum
                    + longint'(g.kd) * (err - longint'(prev_err_q));
                // truncate toward zero: shift the magnitude, restore the sign
                mag = (acc < 0) ? -acc : acc;
                mag = mag >> japc_pkg::GAIN_SHIFT;
                if (mag > longint'(japc_pkg::MAX_DUTY))
                    mag = longint'(japc_pkg::MAX_DUTY);
                held_drive_q = 9'((acc < 0) ? -mag : mag);
                error_sum_q  = 24'(sum);
                prev_err_q   = 18'(err);
            end
            japc_pkg::REQ_TARGET:
                target_q = 18'(w.target_angle);
            japc_pkg::REQ_SWITCH:
            begin
                offset_q = 18'(wrap_half_turn(longint'(offset_q) + longint'(target_q) - cal));
                if (w.link_select != active_q)
                begin
                    active_q      = w.link_select;
                    r.set_changed = 1'b1;
                end
            end
            default:
                ;
        endcase
        d = longint'(held_drive_q);
        r.drive       = held_drive_q;
        r.pwm_forward = (d < 0) ? 8'(-d) : 8'd0;
        r.pwm_reverse = (d > 0) ? 8'(d) : 8'd0;
        r.gain_set    = active_q;
    endtask

    task automatic compare_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_bank[0] = '{kp: 16'd256, ki: 16'd0, kd: 16'd0};
            gain_bank[1] = '{kp: 16'd256, ki: 16'd0, kd: 16'd0};
            sum_limit    = 23'd25600;
            target_q     = '0;
            prev_err_q   = '0;
            offset_q     = '0;  // initial offset register resets to zero
            error_sum_q  = '0;
            held_drive_q = '0;
            active_q     = 1'b0;
            pending_efforts.delete();
            mismatch_count = 0;
            efforts_due    = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    japc_pkg::CFG_KP_A:        gain_bank[0].kp = cfg_data[15:0];
                    japc_pkg::CFG_KI_A:        gain_bank[0].ki = cfg_data[15:0];
                    japc_pkg::CFG_KD_A:        gain_bank[0].kd = cfg_data[15:0];
                    japc_pkg::CFG_KP_D:        gain_bank[1].kp = cfg_data[15:0];
                    japc_pkg::CFG_KI_D:        gain_bank[1].ki = cfg_data[15:0];
                    japc_pkg::CFG_KD_D:        gain_bank[1].kd = cfg_data[15:0];
                    japc_pkg::CFG_INT_LIMIT:   sum_limit = cfg_data;
                    japc_pkg::CFG_INIT_OFFSET: ;  // only loaded by reset
                    default:                   ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                in_word.req_type     = req_type;
                in_word.angle_sample = angle_sample;
                in_word.target_angle = target_angle;
                in_word.link_select  = link_select;
                advance_joint(in_word, want_word);
                pending_efforts.push_back(want_word);
            end
            if (out_valid && out_ready)
            begin
                seen_word = '{drive, pwm_forward, pwm_reverse, gain_set, set_changed};
                if (pending_efforts.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, drive %0d", $time,
                             drive);
                    mismatch_count++;
                end
                else
                begin
                    want_word = pending_efforts.pop_front();
                    compare_field("drive", want_word.drive, seen_word.drive);
                    compare_field("pwm_forward", want_word.pwm_forward,
                                  seen_word.pwm_forward);
                    compare_field("pwm_reverse", want_word.pwm_reverse,
                                  seen_word.pwm_reverse);
                    compare_field("gain_set", want_word.gain_set, seen_word.gain_set);
                    compare_field("set_changed", want_word.set_changed,
                                  seen_word.set_changed);
                end
            end
            efforts_due = pending_efforts.size();
        end
    end

endmodule

### verif/joint_angle_pid_controller_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the joint angle PID unit: clock, reset, config, stimulus and verdict
module joint_angle_pid_controller_unit_tb;

    localparam logic [1:0] REQ_SPARE   = 2'd3;  // unused code, must leave state alone
    localparam int         HOLD_CYCLES = 64;
    localparam int         PHASES      = 8;
    localparam int         PHASE_WORDS = 150;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [22:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         req_type;
    logic [16:0]        angle_sample;
    logic signed [16:0] target_angle;
    logic               link_select;
    logic               out_valid;
    logic               out_ready;
    logic signed [8:0]  drive;
    logic [7:0]         pwm_forward;
    logic [7:0]         pwm_reverse;
    logic               gain_set;
    logic               set_changed;

    int   mismatch_count;
    int   efforts_due;
    logic idle_on;
    int   hold_reqs = 0;

    always #5 clk = ~clk;

    joint_angle_pid_controller_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .angle_sample (angle_sample),
        .target_angle (target_angle),
        .link_select  (link_select),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive        (drive),
        .pwm_forward  (pwm_forward),
        .pwm_reverse  (pwm_reverse),
        .gain_set     (gain_set),
        .set_changed  (set_changed)
    );

    japc_effort_check i_effort_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .angle_sample   (angle_sample),
        .target_angle   (target_angle),
        .link_select    (link_select),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive          (drive),
        .pwm_forward    (pwm_forward),
        .pwm_reverse    (pwm_reverse),
        .gain_set       (gain_set),
        .set_changed    (set_changed),
        .mismatch_count (mismatch_count),
        .efforts_due    (efforts_due)
    );

    // offers one word, returns at the edge that takes it
    task automatic send_word(input logic [1:0] req, input logic [16:0] ang,
                             input logic signed [16:0] tgt, input logic lnk);
        while (idle_on && $urandom_range(99) < 18)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        req_type     <= req;
        angle_sample <= ang;
        target_angle <= tgt;
        link_select  <= lnk;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random_word();
        int                 pick;
        logic [1:0]         req;
        logic [16:0]        ang;
        logic signed [16:0] tgt;
        pick = $urandom_range(99);
        if (pick < 70)
            req = japc_pkg::REQ_TICK;
        else if (pick < 83)
            req = japc_pkg::REQ_TARGET;
        else if (pick < 97)
            req = japc_pkg::REQ_SWITCH;
        else
            req = REQ_SPARE;
        // mostly in-range angles and targets, now and then the full field
        if ($urandom_range(9) == 0)
            ang = 17'($urandom);
        else
            ang = 17'($urandom_range(92159));
        if ($urandom_range(9) == 0)
            tgt = 17'($urandom);
        else
            tgt = 17'(int'($urandom_range(92160)) - 46080);
        send_word(req, ang, tgt, 1'($urandom));
    endtask

    // drop valid and wait until every expected word is back, plus pipeline depth
    task automatic settle_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (efforts_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [22:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    function automatic logic [22:0] pick_gain();
        case ($urandom_range(3))
            0:       return 23'($urandom_range(512));
            1:       return 23'($urandom_range(4096));
            2:       return 23'($urandom_range(65535));
            default: return 23'($urandom);  // upper bits must be ignored
        endcase
    endfunction

    task automatic program_phase(input int phase);
        logic [22:0] g [6];
        logic [22:0] lim;
        logic [22:0] ofs;
        int          k;
        for (k = 0; k < 6; k++)
        begin
            if (phase == 0)
                g[k] = '0;
            else if (phase == 1)
                g[k] = 23'd65535;
            else
                g[k] = pick_gain();
        end
        if (phase == 0)
        begin
            lim = '0;
            ofs = 23'(17'(-46079));
        end
        else if (phase == 1)
        begin
            lim = 23'd8388607;
            ofs = 23'd46080;
        end
        else
        begin
            lim = $urandom_range(1) ? 23'($urandom_range(4096)) : 23'($urandom);
            ofs = 23'($urandom);
        end
        write_reg(japc_pkg::CFG_KP_A, g[0]);
        write_reg(japc_pkg::CFG_KI_A, g[1]);
        write_reg(japc_pkg::CFG_KD_A, g[2]);
        write_reg(japc_pkg::CFG_KP_D, g[3]);
        write_reg(japc_pkg::CFG_KI_D, g[4]);
        write_reg(japc_pkg::CFG_KD_D, g[5]);
        write_reg(japc_pkg::CFG_INT_LIMIT, lim);
        write_reg(japc_pkg::CFG_INIT_OFFSET, ofs);
        cfg_wr_en <= 1'b0;
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_served;
        hold_served = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != hold_served)
            begin
                hold_served = hold_reqs;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= !(idle_on && $urandom_range(99) < 18);
        end
    end

    initial
    begin
        int phase;
        int n;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        req_type     = '0;
        angle_sample = '0;
        target_angle = '0;
        link_select  = 1'b0;
        idle_on      = 1'b1;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed words on reset gains
        send_word(japc_pkg::REQ_TICK,   17'd0,      17'sd0,      1'b0);
        send_word(japc_pkg::REQ_TARGET, 17'd0,      17'sd46080,  1'b0);
        send_word(japc_pkg::REQ_TICK,   17'd0,      17'sd0,      1'b0);
        send_word(japc_pkg::REQ_TICK,   17'd92159,  17'sd0,      1'b0);  // calibrated angle wraps negative
        send_word(japc_pkg::REQ_TARGET, 17'd0,      -17'sd46080, 1'b0);
        send_word(japc_pkg::REQ_TICK,   17'd46080,  17'sd0,      1'b0);  // error wraps up to zero
        send_word(japc_pkg::REQ_TICK,   17'h1FFFF,  17'sd0,      1'b1);  // sample out of range
        send_word(japc_pkg::REQ_TARGET, 17'd0,      17'sh0FFFF,  1'b0);
        send_word(japc_pkg::REQ_TICK,   17'd100,    17'sd0,      1'b0);
        send_word(japc_pkg::REQ_TARGET, 17'd0,      17'sh10000,  1'b1);
        send_word(japc_pkg::REQ_TICK,   17'd0,      17'sd0,      1'b0);
        send_word(japc_pkg::REQ_SWITCH, 17'd5000,   17'sd0,      1'b0);  // same set, no change
        send_word(japc_pkg::REQ_SWITCH, 17'd12345,  17'sd0,      1'b1);
        send_word(japc_pkg::REQ_SWITCH, 17'h1FFFF,  17'sd0,      1'b1);
        send_word(REQ_SPARE,            17'h1FFFF,  17'sh0ABCD,  1'b1);
        send_word(japc_pkg::REQ_TICK,   17'd12345,  17'sd0,      1'b0);
        send_word(japc_pkg::REQ_SWITCH, 17'd0,      17'sd0,      1'b0);
        send_word(japc_pkg::REQ_TARGET, 17'd0,      17'sd0,      1'b0);
        send_word(japc_pkg::REQ_TICK,   17'd46081,  17'sd0,      1'b0);
        send_word(REQ_SPARE,            17'd0,      17'sd0,      1'b0);
        send_word(japc_pkg::REQ_TICK,   17'd1,      17'sd0,      1'b0);
        settle_pipeline();

        for (phase = 0; phase < PHASES; phase++)
        begin
            program_phase(phase);
            idle_on = (phase != 4);
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if ((phase == 2 || phase == 4) && n == 30)
                    hold_reqs++;
                send_random_word();
            end
            settle_pipeline();
        end

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
